// ===== src/eprom_programmer_port_logic_defines.svh =====
// ---------------------------------------------------------------------------
// EPROM programmer port logic: assertion macros
// Shared concurrent assertion forms for the port logic block.
// ---------------------------------------------------------------------------
`ifndef EPROM_PROGRAMMER_PORT_LOGIC_DEFINES_SVH
`define EPROM_PROGRAMMER_PORT_LOGIC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPPL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EPPL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/epp_pkg.sv =====
// ---------------------------------------------------------------------------
// EPROM programmer port logic package
// Command codes, port bit positions and the item and pin types.
// ---------------------------------------------------------------------------
`default_nettype none

package epp_pkg;

    localparam int unsigned ADDR_BITS_DEFAULT = 24;
    localparam int unsigned ADDR_OUT_BITS     = 24;

    // Port access codes.
    localparam logic [1:0] CMD_DATA_WR   = 2'd0;
    localparam logic [1:0] CMD_CTRL_WR   = 2'd1;
    localparam logic [1:0] CMD_STATUS_RD = 2'd2;

    // Control port bits.
    localparam int unsigned CTL_VPP = 0;
    localparam int unsigned CTL_OE  = 1;
    localparam int unsigned CTL_VDD = 2;
    localparam int unsigned CTL_WE  = 3;

    // Data port bits, parallel address/data mode.
    localparam int unsigned DAT_ACLK  = 0;
    localparam int unsigned DAT_ADATA = 1;
    localparam int unsigned DAT_DCLK  = 2;

    // Data port bits, serial device mode.
    localparam int unsigned DAT_SDIN = 0;
    localparam int unsigned DAT_SCLK = 1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] port_value;
        logic [7:0] data_bus_in;
        logic       serial_data_in;
    } item_t;

    typedef struct packed {
        logic vpp;
        logic oe;
        logic vdd;
        logic we;
        logic cs;
        logic sclk;
        logic sdin;
    } pins_t;

endpackage

`default_nettype wire

// ===== src/epp_port_state.sv =====
// ---------------------------------------------------------------------------
// EPROM programmer port state
// Port mirrors, shift registers, held pin levels and status bits, updated
// by one port access per enabled cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module epp_port_state #(
    parameter int unsigned ADDR_BITS = epp_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 update,
    input  wire epp_pkg::item_t       item,
    output logic [ADDR_BITS-1:0]      addr,
    output logic [7:0]                data_bus_out,
    output epp_pkg::pins_t            pins,
    output logic [7:0]                status_value
);

    logic [3:0]           ctl_reg,   ctl_next;
    logic [2:0]           dat_reg,   dat_next;
    logic [ADDR_BITS-1:0] addr_reg,  addr_next;
    logic [7:0]           dsh_reg,   dsh_next;
    logic [7:0]           latch_reg, latch_next;
    epp_pkg::pins_t       pins_reg,  pins_next;
    logic                 hdw_reg,   hdw_next;
    logic                 serin_reg, serin_next;

    logic [3:0] ctl_chg;
    logic [2:0] dat_chg;
    logic [7:0] nv;
    logic       oe_off;
    logic       sdo_forced;
    logic [7:0] dsh_clocked;

    assign nv      = item.port_value;
    assign ctl_chg = ctl_reg ^ nv[3:0];
    assign dat_chg = dat_reg ^ nv[2:0];
    assign oe_off  = ctl_reg[epp_pkg::CTL_OE];

    assign dsh_clocked = (nv[epp_pkg::DAT_ADATA] && !oe_off) ? item.data_bus_in
                                                             : {dsh_reg[6:0], 1'b0};

    always_comb
    begin
        ctl_next   = ctl_reg;
        dat_next   = dat_reg;
        addr_next  = addr_reg;
        dsh_next   = dsh_reg;
        latch_next = latch_reg;
        pins_next  = pins_reg;
        hdw_next   = hdw_reg;
        serin_next = serin_reg;
        sdo_forced = 1'b0;

        unique case (item.cmd)
            epp_pkg::CMD_CTRL_WR:
            begin
                ctl_next = nv[3:0];
                if (ctl_chg[epp_pkg::CTL_VPP])
                begin
                    pins_next.vpp = !nv[epp_pkg::CTL_VPP];
                end
                if (ctl_chg[epp_pkg::CTL_OE])
                begin
                    pins_next.oe = !nv[epp_pkg::CTL_OE];
                end
                if (ctl_chg[epp_pkg::CTL_VDD])
                begin
                    pins_next.vdd = nv[epp_pkg::CTL_VDD];
                end
                if (ctl_chg[epp_pkg::CTL_WE])
                begin
                    pins_next.we = nv[epp_pkg::CTL_WE];
                    pins_next.cs = !nv[epp_pkg::CTL_WE];
                end
            end
            epp_pkg::CMD_DATA_WR:
            begin
                dat_next = nv[2:0];
                if (oe_off)
                begin
                    latch_next = nv;
                    if (dat_chg[epp_pkg::DAT_SCLK])
                    begin
                        pins_next.sclk = nv[epp_pkg::DAT_SCLK];
                        if (nv[epp_pkg::DAT_SCLK])
                        begin
                            pins_next.sdin = nv[epp_pkg::DAT_SDIN];
                            // The serial data-out pin reads back inverted.
                            sdo_forced = !item.serial_data_in;
                        end
                    end
                end
                else if (dat_chg[epp_pkg::DAT_ACLK] && nv[epp_pkg::DAT_ACLK])
                begin
                    addr_next = {addr_reg[ADDR_BITS-2:0], nv[epp_pkg::DAT_ADATA]};
                end

                if (dat_chg[epp_pkg::DAT_DCLK] && !nv[epp_pkg::DAT_DCLK])
                begin
                    dsh_next   = dsh_clocked;
                    serin_next = !dsh_clocked[7];
                end

                hdw_next = sdo_forced
                        || (!nv[epp_pkg::DAT_ACLK] && ctl_reg[epp_pkg::CTL_VDD]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            dat_reg   <= '0;
            addr_reg  <= '1;
            dsh_reg   <= '0;
            latch_reg <= '0;
            pins_reg  <= '0;
            hdw_reg   <= 1'b0;
            serin_reg <= 1'b0;
        end
        else if (update)
        begin
            ctl_reg   <= ctl_next;
            dat_reg   <= dat_next;
            addr_reg  <= addr_next;
            dsh_reg   <= dsh_next;
            latch_reg <= latch_next;
            pins_reg  <= pins_next;
            hdw_reg   <= hdw_next;
            serin_reg <= serin_next;
        end
    end

    assign addr         = addr_reg;
    assign data_bus_out = latch_reg;
    assign pins         = pins_reg;
    assign status_value = {hdw_reg, serin_reg, 6'b0};

endmodule

`default_nettype wire

// ===== src/eprom_programmer_port_logic.sv =====
// ---------------------------------------------------------------------------
// EPROM programmer port logic
// Models the port side of a parallel-port EPROM programmer: port mirrors,
// address and data shift registers, held pin levels and the status byte.
// ---------------------------------------------------------------------------
// Usage:
// Each transaction on the request channel (req_valid, req_stall) is one port
// access: a data-port write, a control-port write or a status read, with the
// sampled chip data bus and serial data-out level. Every request yields
// exactly one transaction on the response channel (rsp_valid, rsp_stall)
// that carries the address, data bus, pin levels and status byte after it.
// A request is held in an input register and then applied to the port state
// once the response channel can advance; the response valid flag is set with
// that update. The state registers themselves drive the response fields.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the single update pass. When the receiver stalls, the response holds
// and the state stays frozen; one more request is still taken into the input
// register, after which req_stall follows rsp_stall.
// Reset clears the mirrors, pins and status byte and sets the address shift
// register to all ones; no response is pending after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "eprom_programmer_port_logic_defines.svh"

module eprom_programmer_port_logic #(
    parameter int unsigned ADDR_BITS = epp_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  port_value,
    input  wire logic [7:0]  data_bus_in,
    input  wire logic        serial_data_in,

    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [23:0]      addr_bus,
    output logic [7:0]       data_bus_out,
    output logic             vpp_on,
    output logic             oe_on,
    output logic             vdd_on,
    output logic             we_on,
    output logic             sdev_cs,
    output logic             sdev_clk,
    output logic             sdev_din,
    output logic [7:0]       status_value
);

    epp_pkg::item_t       item_reg;
    logic                 item_valid_reg, item_valid_next;
    logic                 rsp_valid_reg,  rsp_valid_next;
    logic                 advance;
    logic                 state_update;
    logic                 req_accept;
    logic [ADDR_BITS-1:0] addr_state;
    epp_pkg::pins_t       pins;

    assign advance         = !rsp_valid_reg || !rsp_stall;
    assign state_update    = item_valid_reg && advance;
    assign req_stall       = item_valid_reg && !advance;
    assign req_accept      = req_valid && !req_stall;
    assign item_valid_next = req_accept || (item_valid_reg && !advance);
    assign rsp_valid_next  = state_update || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            item_reg.cmd            <= cmd;
            item_reg.port_value     <= port_value;
            item_reg.data_bus_in    <= data_bus_in;
            item_reg.serial_data_in <= serial_data_in;
        end
    end

    epp_port_state #(
        .ADDR_BITS (ADDR_BITS)
    ) u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (state_update),
        .item         (item_reg),
        .addr         (addr_state),
        .data_bus_out (data_bus_out),
        .pins         (pins),
        .status_value (status_value)
    );

    // Narrow address registers are zero-extended, wide ones show the low bits.
    assign addr_bus   = epp_pkg::ADDR_OUT_BITS'(addr_state);
    assign rsp_valid  = rsp_valid_reg;
    assign vpp_on     = pins.vpp;
    assign oe_on      = pins.oe;
    assign vdd_on     = pins.vdd;
    assign we_on      = pins.we;
    assign sdev_cs    = pins.cs;
    assign sdev_clk   = pins.sclk;
    assign sdev_din   = pins.sdin;

    `EPPL_ASSERT_IMP(a_stall_needs_item, clk, rst_n, req_stall, item_valid_reg, "request stalled with empty input register")
    `EPPL_ASSERT_NXT(a_update_gives_rsp, clk, rst_n, state_update, rsp_valid, "state update without a response")
    `EPPL_ASSERT_NXT(a_addr_hold, clk, rst_n, !state_update, $stable(addr_bus), "address changed without an update")
    `EPPL_ASSERT_IMP(a_we_cs_excl, clk, rst_n, 1'b1, !(we_on && sdev_cs), "write enable and serial select both high")

endmodule

`default_nettype wire
